// ----- src/tic_pkg.sv -----
// Shared widths and payload types of the triangle incircle pipeline.
package tic_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SIDE_W     = SQ_W / 2;
  localparam int PER_W      = SIDE_W + 2;
  localparam int PROD_W     = 3 * PER_W;
  localparam int NUM_W      = COORD_W + SIDE_W + 2;
  localparam int DVS_W      = PER_W + 2;
  localparam int DIVD_W     = PROD_W;
  localparam int RAD_W      = PROD_W + (PROD_W % 2);
  localparam int RT_W       = RAD_W / 2;
  localparam int RAD_OUT_W  = COORD_W - 1;
  localparam int SQR_REM_W  = RT_W + 3;
  localparam int SQR_ROOT_W = RT_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } tic_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_OUT_W-1:0]      in_radius;
    logic                      degenerate;
  } tic_out_t;

endpackage

// ----- src/triangle_incircle_top.sv -----
// Triangle incircle pipeline: side lengths, Heron inradius and incenter.
//
// One triangle enters per clock. The pipeline is a chain of registered stages,
// among them bit-serial ones: 17 stages take the side
// square roots, 57 stages run the three restoring dividers (one quotient bit
// each) and 29 stages take the square root of the squared inradius. When the
// output transfer stalls, the whole pipeline holds and in_stall_o rises in the
// same cycle; no item is lost or repeated.
module triangle_incircle_top import tic_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tic_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tic_out_t out_data_o
);

  typedef struct packed {
    logic [SQR_REM_W-1:0]  rem;
    logic [SQR_ROOT_W-1:0] root;
  } sqr_t;

  typedef struct packed {
    logic [SQ_W-1:0]   s;
    logic [SIDE_W+1:0] rem;
    logic [SIDE_W-1:0] root;
  } sds_t;

  typedef struct packed {
    logic [DIVD_W-1:0] dq;
    logic [DVS_W-1:0]  rem;
  } dvs_t;

  typedef struct packed {
    logic [RAD_W-1:0]  s;
    logic [RT_W+1:0]   rem;
    logic [RT_W-1:0]   root;
  } rts_t;

  localparam logic [DIVD_W-1:0] HalfRange = DIVD_W'(1) << (COORD_W - 1);
  localparam logic [COORD_W-1:0] MaxPos = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] MinNeg = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [RT_W-1:0] MaxRad = RT_W'({RAD_OUT_W{1'b1}});

  // One step of the restoring square root: two radicand bits in, one root bit out.
  function automatic sqr_t sqr_step(input logic [SQR_REM_W-1:0] rem,
                                    input logic [SQR_ROOT_W-1:0] root,
                                    input logic [1:0] two);
    logic [SQR_REM_W-1:0] t;
    logic [SQR_REM_W-1:0] trial;
    sqr_t r;
    t = {rem[SQR_REM_W-3:0], two};
    trial = {1'b0, root, 2'b01};
    if (t >= trial) begin
      r.rem = t - trial;
      r.root = {root[SQR_ROOT_W-2:0], 1'b1};
    end else begin
      r.rem = t;
      r.root = {root[SQR_ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] round_clamp(input logic [DIVD_W-1:0] q,
                                                     input logic neg);
    logic [COORD_W-1:0] r;
    if (neg) begin
      if (q >= HalfRange) r = MinNeg;
      else r = COORD_W'(DIVD_W'(0) - q);
    end else begin
      if (q > DIVD_W'(MaxPos)) r = MaxPos;
      else r = COORD_W'(q);
    end
    return r;
  endfunction

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Stage A: vertex differences.
  logic                     a_v_q;
  tic_in_t                  a_vtx_q;
  logic signed [DIFF_W-1:0] a_dif_q [6];
  logic signed [DIFF_W-1:0] a_dif_d [6];

  always_comb begin
    a_dif_d[0] = DIFF_W'(in_data_i.cx) - DIFF_W'(in_data_i.bx);
    a_dif_d[1] = DIFF_W'(in_data_i.cy) - DIFF_W'(in_data_i.by);
    a_dif_d[2] = DIFF_W'(in_data_i.ax) - DIFF_W'(in_data_i.cx);
    a_dif_d[3] = DIFF_W'(in_data_i.ay) - DIFF_W'(in_data_i.cy);
    a_dif_d[4] = DIFF_W'(in_data_i.bx) - DIFF_W'(in_data_i.ax);
    a_dif_d[5] = DIFF_W'(in_data_i.by) - DIFF_W'(in_data_i.ay);
  end

  // Stage B: squared side lengths.
  logic            b_v_q;
  tic_in_t         b_vtx_q;
  logic [SQ_W-1:0] b_s_q [3];
  logic [SQ_W-1:0] b_s_d [3];

  always_comb begin
    logic signed [SQ_W-1:0] tx;
    logic signed [SQ_W-1:0] ty;
    for (int e = 0; e < 3; e++) begin
      tx = SQ_W'(a_dif_q[2*e]) * SQ_W'(a_dif_q[2*e]);
      ty = SQ_W'(a_dif_q[2*e+1]) * SQ_W'(a_dif_q[2*e+1]);
      b_s_d[e] = $unsigned(tx + ty);
    end
  end

  // Stages C: side square roots.
  sds_t              sd_q [SIDE_W][3];
  sds_t              sd_d [SIDE_W][3];
  tic_in_t           sd_vtx_q [SIDE_W];
  logic [SIDE_W-1:0] sd_v_q;

  always_comb begin
    sds_t src;
    sqr_t st;
    for (int k = 0; k < SIDE_W; k++) begin
      for (int e = 0; e < 3; e++) begin
        if (k == 0) begin
          src.s = b_s_q[e];
          src.rem = '0;
          src.root = '0;
        end else begin
          src = sd_q[k-1][e];
        end
        st = sqr_step(SQR_REM_W'(src.rem), SQR_ROOT_W'(src.root),
                      src.s[SQ_W-1-2*k -: 2]);
        sd_d[k][e].s = src.s;
        sd_d[k][e].rem = (SIDE_W+2)'(st.rem);
        sd_d[k][e].root = SIDE_W'(st.root);
      end
    end
  end

  // Stage D: perimeter and Heron factors.
  logic              d_v_q;
  tic_in_t           d_vtx_q;
  logic [SIDE_W-1:0] d_l_q [3];
  logic [PER_W-1:0]  d_f_q [3];
  logic [PER_W-1:0]  d_p_q;
  logic              d_dg_q;
  logic [PER_W-1:0]  d_f_d [3];
  logic [PER_W-1:0]  d_p_d;
  logic              d_dg_d;

  always_comb begin
    logic [PER_W-1:0] other;
    d_p_d = PER_W'(sd_q[SIDE_W-1][0].root) + PER_W'(sd_q[SIDE_W-1][1].root)
          + PER_W'(sd_q[SIDE_W-1][2].root);
    d_dg_d = (d_p_d == '0);
    for (int e = 0; e < 3; e++) begin
      other = d_p_d - PER_W'(sd_q[SIDE_W-1][e].root);
      d_f_d[e] = other - PER_W'(sd_q[SIDE_W-1][e].root);
      if (other <= PER_W'(sd_q[SIDE_W-1][e].root)) d_dg_d = 1'b1;
    end
  end

  // Stage E: first products.
  logic                    e_v_q;
  logic [2*PER_W-1:0]      e_fab_q;
  logic [PER_W-1:0]        e_fc_q;
  logic signed [NUM_W-1:0] e_pr_q [6];
  logic [PER_W-1:0]        e_p_q;
  logic                    e_dg_q;
  logic signed [NUM_W-1:0] e_pr_d [6];

  always_comb begin
    e_pr_d[0] = $signed(NUM_W'(d_vtx_q.ax)) * $signed(NUM_W'(d_l_q[0]));
    e_pr_d[1] = $signed(NUM_W'(d_vtx_q.bx)) * $signed(NUM_W'(d_l_q[1]));
    e_pr_d[2] = $signed(NUM_W'(d_vtx_q.cx)) * $signed(NUM_W'(d_l_q[2]));
    e_pr_d[3] = $signed(NUM_W'(d_vtx_q.ay)) * $signed(NUM_W'(d_l_q[0]));
    e_pr_d[4] = $signed(NUM_W'(d_vtx_q.by)) * $signed(NUM_W'(d_l_q[1]));
    e_pr_d[5] = $signed(NUM_W'(d_vtx_q.cy)) * $signed(NUM_W'(d_l_q[2]));
  end

  // Stage F: Heron product as two partial products, weighted sums.
  logic                    f_v_q;
  logic [2*PER_W-1:0]      f_hi_q;
  logic [2*PER_W-1:0]      f_lo_q;
  logic signed [NUM_W-1:0] f_nx_q;
  logic signed [NUM_W-1:0] f_ny_q;
  logic [PER_W-1:0]        f_p_q;
  logic                    f_dg_q;

  // Stage G: dividends for the three dividers.
  logic              g_v_q;
  logic [DIVD_W-1:0] g_dvd_q [3];
  logic [PER_W-1:0]  g_p_q;
  logic              g_sx_q;
  logic              g_sy_q;
  logic              g_dg_q;
  logic [DIVD_W-1:0] g_dvd_d [3];

  always_comb begin
    logic [NUM_W-1:0] mx;
    logic [NUM_W-1:0] my;
    mx = f_nx_q[NUM_W-1] ? $unsigned(-f_nx_q) : $unsigned(f_nx_q);
    my = f_ny_q[NUM_W-1] ? $unsigned(-f_ny_q) : $unsigned(f_ny_q);
    g_dvd_d[0] = PROD_W'({f_hi_q, PER_W'(0)}) + PROD_W'(f_lo_q);
    g_dvd_d[1] = DIVD_W'({mx, 1'b0}) + DIVD_W'(f_p_q);
    g_dvd_d[2] = DIVD_W'({my, 1'b0}) + DIVD_W'(f_p_q);
  end

  // Stages H: restoring dividers, radius lane by 4p and center lanes by 2p.
  dvs_t              dv_q [DIVD_W][3];
  dvs_t              dv_d [DIVD_W][3];
  logic [PER_W-1:0]  dv_p_q [DIVD_W];
  logic [DIVD_W-1:0] dv_sx_q;
  logic [DIVD_W-1:0] dv_sy_q;
  logic [DIVD_W-1:0] dv_dg_q;
  logic [DIVD_W-1:0] dv_v_q;

  always_comb begin
    dvs_t             src;
    logic [PER_W-1:0] p;
    logic [DVS_W-1:0] dvs;
    logic [DVS_W:0]   t;
    for (int k = 0; k < DIVD_W; k++) begin
      for (int e = 0; e < 3; e++) begin
        if (k == 0) begin
          src.dq = g_dvd_q[e];
          src.rem = '0;
          p = g_p_q;
        end else begin
          src = dv_q[k-1][e];
          p = dv_p_q[k-1];
        end
        dvs = (e == 0) ? {p, 2'b00} : {1'b0, p, 1'b0};
        t = {src.rem, src.dq[DIVD_W-1]};
        if (t >= {1'b0, dvs}) begin
          dv_d[k][e].rem = DVS_W'(t - {1'b0, dvs});
          dv_d[k][e].dq = {src.dq[DIVD_W-2:0], 1'b1};
        end else begin
          dv_d[k][e].rem = DVS_W'(t);
          dv_d[k][e].dq = {src.dq[DIVD_W-2:0], 1'b0};
        end
      end
    end
  end

  // Stage I: center rounding and clamping.
  logic                      i_v_q;
  logic signed [COORD_W-1:0] i_cx_q;
  logic signed [COORD_W-1:0] i_cy_q;
  logic [DIVD_W-1:0]         i_r2_q;
  logic                      i_dg_q;

  // Stages J: square root of the squared inradius.
  rts_t                      rt_q [RT_W];
  rts_t                      rt_d [RT_W];
  logic signed [COORD_W-1:0] rt_cx_q [RT_W];
  logic signed [COORD_W-1:0] rt_cy_q [RT_W];
  logic [RT_W-1:0]           rt_dg_q;
  logic [RT_W-1:0]           rt_v_q;

  always_comb begin
    rts_t src;
    sqr_t st;
    for (int k = 0; k < RT_W; k++) begin
      if (k == 0) begin
        src.s = RAD_W'(i_r2_q);
        src.rem = '0;
        src.root = '0;
      end else begin
        src = rt_q[k-1];
      end
      st = sqr_step(SQR_REM_W'(src.rem), SQR_ROOT_W'(src.root),
                    src.s[RAD_W-1-2*k -: 2]);
      rt_d[k].s = src.s;
      rt_d[k].rem = (RT_W+2)'(st.rem);
      rt_d[k].root = RT_W'(st.root);
    end
  end

  // Output register.
  logic     out_valid_q;
  tic_out_t out_data_q;
  tic_out_t out_data_d;

  always_comb begin
    if (rt_dg_q[RT_W-1]) begin
      out_data_d = '0;
      out_data_d.degenerate = 1'b1;
    end else begin
      out_data_d.center_x = rt_cx_q[RT_W-1];
      out_data_d.center_y = rt_cy_q[RT_W-1];
      out_data_d.in_radius = (rt_q[RT_W-1].root > MaxRad) ? RAD_OUT_W'(MaxRad)
                           : RAD_OUT_W'(rt_q[RT_W-1].root);
      out_data_d.degenerate = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      sd_v_q <= '0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      dv_v_q <= '0;
      i_v_q <= 1'b0;
      rt_v_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      sd_v_q <= {sd_v_q[SIDE_W-2:0], b_v_q};
      d_v_q <= sd_v_q[SIDE_W-1];
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      dv_v_q <= {dv_v_q[DIVD_W-2:0], g_v_q};
      i_v_q <= dv_v_q[DIVD_W-1];
      rt_v_q <= {rt_v_q[RT_W-2:0], i_v_q};
      out_valid_q <= rt_v_q[RT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_vtx_q <= in_data_i;
      a_dif_q <= a_dif_d;
      b_vtx_q <= a_vtx_q;
      b_s_q <= b_s_d;
      for (int k = 0; k < SIDE_W; k++) begin
        sd_q[k] <= sd_d[k];
        sd_vtx_q[k] <= (k == 0) ? b_vtx_q : sd_vtx_q[k-1];
      end
      d_vtx_q <= sd_vtx_q[SIDE_W-1];
      for (int e = 0; e < 3; e++) begin
        d_l_q[e] <= sd_q[SIDE_W-1][e].root;
      end
      d_f_q <= d_f_d;
      d_p_q <= d_p_d;
      d_dg_q <= d_dg_d;
      e_fab_q <= d_f_q[0] * d_f_q[1];
      e_fc_q <= d_f_q[2];
      e_pr_q <= e_pr_d;
      e_p_q <= d_p_q;
      e_dg_q <= d_dg_q;
      f_hi_q <= e_fab_q[2*PER_W-1:PER_W] * e_fc_q;
      f_lo_q <= e_fab_q[PER_W-1:0] * e_fc_q;
      f_nx_q <= e_pr_q[0] + e_pr_q[1] + e_pr_q[2];
      f_ny_q <= e_pr_q[3] + e_pr_q[4] + e_pr_q[5];
      f_p_q <= e_p_q;
      f_dg_q <= e_dg_q;
      g_dvd_q <= g_dvd_d;
      g_p_q <= f_p_q;
      g_sx_q <= f_nx_q[NUM_W-1];
      g_sy_q <= f_ny_q[NUM_W-1];
      g_dg_q <= f_dg_q;
      for (int k = 0; k < DIVD_W; k++) begin
        dv_q[k] <= dv_d[k];
        dv_p_q[k] <= (k == 0) ? g_p_q : dv_p_q[k-1];
      end
      dv_sx_q <= {dv_sx_q[DIVD_W-2:0], g_sx_q};
      dv_sy_q <= {dv_sy_q[DIVD_W-2:0], g_sy_q};
      dv_dg_q <= {dv_dg_q[DIVD_W-2:0], g_dg_q};
      i_cx_q <= round_clamp(dv_q[DIVD_W-1][1].dq, dv_sx_q[DIVD_W-1]);
      i_cy_q <= round_clamp(dv_q[DIVD_W-1][2].dq, dv_sy_q[DIVD_W-1]);
      i_r2_q <= dv_q[DIVD_W-1][0].dq;
      i_dg_q <= dv_dg_q[DIVD_W-1];
      for (int k = 0; k < RT_W; k++) begin
        rt_q[k] <= rt_d[k];
        rt_cx_q[k] <= (k == 0) ? i_cx_q : rt_cx_q[k-1];
        rt_cy_q[k] <= (k == 0) ? i_cy_q : rt_cy_q[k-1];
      end
      rt_dg_q <= {rt_dg_q[RT_W-2:0], i_dg_q};
      out_data_q <= out_data_d;
    end
  end

  // Input is held back only while a finished result waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without an output stall");

  // A degenerate triangle reports all-zero geometry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.center_x == '0 && out_data_o.center_y == '0 &&
       out_data_o.in_radius == '0))
    else $error("degenerate result with nonzero fields");

  // The first side root leaving the square-root stages is the floor root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_v_q[SIDE_W-1] |->
      ((SQ_W+2)'(sd_q[SIDE_W-1][0].root) * (SQ_W+2)'(sd_q[SIDE_W-1][0].root)
         <= (SQ_W+2)'(sd_q[SIDE_W-1][0].s) &&
       ((SQ_W+2)'(sd_q[SIDE_W-1][0].root) + 1) *
       ((SQ_W+2)'(sd_q[SIDE_W-1][0].root) + 1)
         > (SQ_W+2)'(sd_q[SIDE_W-1][0].s)))
    else $error("side square root out of bounds");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the triangle incircle pipeline: random and directed triangles.
module tb;
  import tic_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  tic_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tic_out_t out_data_o;

  int unsigned mismatch_count = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_off = 1'b0;
  int unsigned sent_count = 0;

  triangle_incircle_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint side_length(input longint x0, y0, x1, y1);
    longint dx;
    longint dy;
    dx = x1 - x0;
    dy = y1 - y0;
    return longint'(int_sqrt(longint'(dx * dx + dy * dy)));
  endfunction

  // Rounded division, ties away from zero, clamped to the coordinate range.
  function automatic logic signed [COORD_W-1:0] round_center(input longint num, input longint p);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + p) / (2 * p);
    if (num < 0) q = -q;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[COORD_W-1:0];
  endfunction

  function automatic tic_out_t incircle_of(input tic_in_t t);
    tic_out_t res;
    longint ax, ay, bx, by, cx, cy, la, lb, lc, p, fa, fb, fc;
    longint unsigned r;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
    la = side_length(bx, by, cx, cy);
    lb = side_length(cx, cy, ax, ay);
    lc = side_length(ax, ay, bx, by);
    p = la + lb + lc;
    fa = p - 2 * la;
    fb = p - 2 * lb;
    fc = p - 2 * lc;
    res = '0;
    if (p <= 0 || fa <= 0 || fb <= 0 || fc <= 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    r = int_sqrt((longint'(fa) * fb * fc) / (4 * p));
    if (r > 32767) r = 32767;
    res.in_radius = r[RAD_OUT_W-1:0];
    res.center_x = round_center(ax * la + bx * lb + cx * lc, p);
    res.center_y = round_center(ay * la + by * lb + cy * lc, p);
    return res;
  endfunction

  class incircle_scoreboard;
    tic_out_t    pending[$];
    int unsigned checked = 0;
    int unsigned degenerate_seen = 0;

    function void note_triangle(tic_in_t t);
      pending.push_back(incircle_of(t));
    endfunction

    task check_result(tic_out_t got);
      tic_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.degenerate) degenerate_seen++;
      if (got.center_x !== want.center_x)
        report_mismatch("center_x", got.center_x, want.center_x);
      if (got.center_y !== want.center_y)
        report_mismatch("center_y", got.center_y, want.center_y);
      if (got.in_radius !== want.in_radius)
        report_mismatch("in_radius", got.in_radius, want.in_radius);
      if (got.degenerate !== want.degenerate)
        report_mismatch("degenerate", got.degenerate, want.degenerate);
    endtask
  endclass

  incircle_scoreboard board = new();

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_triangle(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // Receiver side: random stall bursts, one long hold-off, none at the end.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        n = 0;
        while (n < 300) begin
          @(posedge clk_i);
          n++;
        end
        out_stall_i <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom_range(0, 65535));
      1: return COORD_W'($urandom_range(0, 2047) - 1024);
      2: return $urandom_range(0, 1) ? COORD_W'(16'sh7fff - $urandom_range(0, 7)) :
                                     COORD_W'(16'sh8000 + $urandom_range(0, 7));
      default: return COORD_W'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic tic_in_t random_triangle();
    tic_in_t t;
    int k;
    t.ax = rand_coord(); t.ay = rand_coord();
    t.bx = rand_coord(); t.by = rand_coord();
    t.cx = rand_coord(); t.cy = rand_coord();
    case ($urandom_range(0, 15))
      0: begin t.bx = t.ax; t.by = t.ay; end
      1: begin
        // Collinear: C on the line through A with a step that is a multiple.
        k = $urandom_range(1, 4);
        t.bx = t.ax + 16'(($urandom_range(0, 200) - 100));
        t.by = t.ay + 16'(($urandom_range(0, 200) - 100));
        t.cx = t.ax + 16'(k * (t.bx - t.ax));
        t.cy = t.ay + 16'(k * (t.by - t.ay));
      end
      2: begin
        t.bx = t.ax + 16'($urandom_range(0, 2));
        t.by = t.ay + 16'($urandom_range(0, 2));
        t.cx = t.ax + 16'($urandom_range(0, 2));
        t.cy = t.ay + 16'($urandom_range(0, 2));
      end
      default: ;
    endcase
    return t;
  endfunction

  // Holds the item until the block takes it; valid stays high for back-to-back items.
  task automatic send_triangle(input tic_in_t t);
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic sender_gap();
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  function automatic tic_in_t make_tri(input int a, b, c, d, e, f);
    tic_in_t t;
    t.ax = COORD_W'(a); t.ay = COORD_W'(b); t.bx = COORD_W'(c);
    t.by = COORD_W'(d); t.cx = COORD_W'(e); t.cy = COORD_W'(f);
    return t;
  endfunction

  initial begin
    tic_in_t directed[$];
    int waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_tri(0, 0, 0, 0, 0, 0));
    directed.push_back(make_tri(1000, -500, 1000, -500, 1000, -500));
    directed.push_back(make_tri(0, 0, 768, 0, 0, 1024));
    directed.push_back(make_tri(0, 0, 256, 256, 512, 512));
    directed.push_back(make_tri(0, 0, 1, 0, 0, 1));
    directed.push_back(make_tri(0, 0, 2, 0, 1, 1));
    directed.push_back(make_tri(-32768, -32768, 32767, -32768, 0, 32767));
    directed.push_back(make_tri(32767, 32767, -32768, 32767, 32767, -32768));
    directed.push_back(make_tri(-32768, -32768, 32767, 32767, -32768, 32767));
    directed.push_back(make_tri(-32768, 0, 32767, 0, 0, 1));
    directed.push_back(make_tri(32767, 32767, 32767, 32766, 32766, 32767));
    directed.push_back(make_tri(-32768, -32768, -32767, -32768, -32768, -32767));
    directed.push_back(make_tri(-32768, -32768, -32768, -32768, 32767, 32767));
    directed.push_back(make_tri(-1, -1, -1, 0, 0, -1));
    directed.push_back(make_tri(21845, -21846, -21846, 21845, 0, 0));
    directed.push_back(make_tri(-100, 200, 300, -400, 500, 600));
    foreach (directed[i]) send_triangle(directed[i]);

    for (int i = 0; i < 1800; i++) begin
      if (i == 1500) quiet_phase = 1'b1;
      if (i == 600) hold_off = 1'b1;
      send_triangle(random_triangle());
      sender_gap();
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (150) @(posedge clk_i);

    $display("Sent %0d triangles, checked %0d results (%0d degenerate).",
             sent_count, board.checked, board.degenerate_seen);
    $display("Directed corners, random triangles and stalls on both sides were covered.");
    if (mismatch_count == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (board.pending.size() != 0)
        report_mismatch("results never arrived", 0, board.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", board.pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
